[rtl/core/repeating_timer_table_top_macros.svh]
// assertion macros for the repeating timer table
// expects signals named clk and arst_n in the scope of use
`ifndef REPEATING_TIMER_TABLE_TOP_MACROS_SVH
`define REPEATING_TIMER_TABLE_TOP_MACROS_SVH

// same-cycle implication, off while in reset
`define RTT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while in reset
`define RTT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/rtt_pkg.sv]
// shared types, codes and helpers of the repeating timer table
// no dependencies
package rtt_pkg;

	localparam int TIME_BITS = 32;
	localparam int COUNT_W   = 16;
	localparam int SLOT_W    = 4;
	localparam int KIND_W    = 3;
	localparam int FUNC_W    = 2;
	localparam int BUDGET_W  = 6;

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [COUNT_W-1:0]   cnt_t;

	localparam cnt_t COUNT_MAX = '1;

	// request codes
	localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;

	// result codes
	localparam logic [KIND_W-1:0] KIND_FIRED      = 3'd0;
	localparam logic [KIND_W-1:0] KIND_TICK_DONE  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_ADDED      = 3'd2;
	localparam logic [KIND_W-1:0] KIND_FULL       = 3'd3;
	localparam logic [KIND_W-1:0] KIND_REMOVED    = 3'd4;
	localparam logic [KIND_W-1:0] KIND_RM_IGNORED = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LOAD,
		ST_EVAL,
		ST_STEP,
		ST_WRITE,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_READ,
		OP_LOAD,
		OP_EVAL,
		OP_FIRE,
		OP_WRITE,
		OP_DONE
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   deferred;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic cur_valid;
		logic due_ok;
		logic fire_due;
		logic period_zero;
	} dp_status_t;

	typedef struct packed {
		time_t start;
		time_t first_delay;
		time_t period;
		cnt_t  limit;
		cnt_t  count;
		logic  started;
		time_t next_fire;
	} entry_t;

	// saturating firing count increment
	function automatic cnt_t bump(input cnt_t c);
		bump = (c == COUNT_MAX) ? COUNT_MAX : c + cnt_t'(1);
	endfunction

endpackage

[rtl/core/rtt_if.sv]
// request and result channel interfaces of the repeating timer table
// depends on rtt_pkg
interface rtt_in_if;
	import rtt_pkg::*;
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	time_t               time_now;
	time_t               first_delay;
	time_t               period;
	cnt_t                repeat_limit;
	logic [SLOT_W-1:0]   slot;

	modport source(output valid, func, time_now, first_delay, period, repeat_limit, slot,
		input ready);
	modport sink(input valid, func, time_now, first_delay, period, repeat_limit, slot,
		output ready);
endinterface

interface rtt_out_if;
	import rtt_pkg::*;
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [SLOT_W-1:0]   timer_slot;
	time_t               fire_time;
	cnt_t                fire_count;
	logic                deferred;
	logic                last;

	modport source(output valid, kind, timer_slot, fire_time, fire_count, deferred, last,
		input ready);
	modport sink(input valid, kind, timer_slot, fire_time, fire_count, deferred, last,
		output ready);
endinterface

[rtl/core/repeating_timer_table_top.sv]
// top level of the repeating timer table: sequencer plus datapath
// depends on rtt_pkg, rtt_if, rtt_ctrl, rtt_datapath and the assertion macros
//
// usage
// - request channel: func selects add (first_delay, period, repeat_limit),
//   remove (slot) or tick (time_now); unknown func codes are taken and dropped
// - result channel: one item for add or remove, and for a tick one item per
//   firing followed by a tick done item; last marks the final item of a request
// - add and remove: the result is in the output register in the cycle after the
//   request is taken
// - tick: a free slot is scanned and passed over; a valid slot is scanned, loaded,
//   evaluated, stepped through its firings and a closing step if due (a period-zero
//   entry fires and closes together), and written back; then the tick done item
// - the rate is set by the single-port entry store, visited one slot at a time
// - ready is high only while the sequencer is idle and the output register is
//   free, so one request is worked on at a time
// - when the receiver stalls, the walk holds on the pending result and resumes
//   once the output register is taken
// - reset clears the valid bits, the time and the output register; entry
//   contents are written by add before use and need no clearing pass
`include "repeating_timer_table_top_macros.svh"

module repeating_timer_table_top #(
	parameter int NUM_TIMERS         = 16,
	parameter int MAX_FIRES_PER_TICK = 63
) (
	input logic       clk,
	input logic       arst_n,
	rtt_in_if.sink    request,
	rtt_out_if.source result
);
	import rtt_pkg::*;

	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	dp_cmd_t          dp_cmd;
	dp_status_t       dp_status;
	logic [IDX_W-1:0] entry_idx;

	// sequencer: intake and the per-slot walk of a tick
	rtt_ctrl #(
		.NUM_TIMERS        (NUM_TIMERS),
		.MAX_FIRES_PER_TICK(MAX_FIRES_PER_TICK)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(request.valid),
		.func     (request.func),
		.req_ready(request.ready),
		.cmd      (dp_cmd),
		.idx      (entry_idx),
		.status   (dp_status)
	);

	// entry store, timer arithmetic and the output register
	rtt_datapath #(
		.NUM_TIMERS(NUM_TIMERS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.func        (request.func),
		.time_now    (request.time_now),
		.first_delay (request.first_delay),
		.period      (request.period),
		.repeat_limit(request.repeat_limit),
		.slot        (request.slot),
		.cmd         (dp_cmd),
		.idx         (entry_idx),
		.status      (dp_status),
		.result      (result)
	);

	// a taken request always reaches the datapath
	`RTT_ASSERT_NOW(a_accept_op, (request.valid && request.ready), (dp_cmd.op == OP_ACCEPT), "request taken without accept op")
	// results are loaded only into a free output register
	`RTT_ASSERT_NOW(a_emit_free, (dp_cmd.op == OP_FIRE || dp_cmd.op == OP_DONE), dp_status.out_free, "result loaded over a pending item")
	// a tick blocks intake while the table is walked
	`RTT_ASSERT_NEXT(a_tick_busy, (request.valid && request.ready && request.func == FUNC_TICK), !request.ready, "request taken during a tick walk")
	// a firing always carries a nonzero count
	`RTT_ASSERT_NOW(a_fire_count, (result.valid && result.kind == KIND_FIRED), (result.fire_count != '0), "firing with zero count")

endmodule

[rtl/core/rtt_ctrl.sv]
// sequencer of the repeating timer table: request intake and entry walk
// depends on rtt_pkg
module rtt_ctrl #(
	parameter int NUM_TIMERS         = 16,
	parameter int MAX_FIRES_PER_TICK = 63
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	input  logic [rtt_pkg::FUNC_W-1:0] func,
	output logic                       req_ready,
	output rtt_pkg::dp_cmd_t           cmd,
	output logic [((NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1)-1:0] idx,
	input  rtt_pkg::dp_status_t        status
);
	import rtt_pkg::*;

	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	state_t              state_q, state_d;
	logic [IDX_W-1:0]    idx_q;
	logic [BUDGET_W-1:0] fires_q;
	logic                defer_q;
	logic                accept;
	logic                idx_last;
	logic                budget_full;

	assign idx_last    = (idx_q == IDX_W'(NUM_TIMERS - 1));
	assign budget_full = (fires_q == BUDGET_W'(MAX_FIRES_PER_TICK));
	assign accept      = req_valid && req_ready;
	assign idx         = idx_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && func == FUNC_TICK) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (status.cur_valid) state_d = ST_LOAD;
				else if (idx_last)    state_d = ST_DONE;
			end
			ST_LOAD: state_d = ST_EVAL;
			ST_EVAL: state_d = status.due_ok ? ST_STEP : ST_WRITE;
			ST_STEP: begin
				if (!status.fire_due || budget_full) state_d = ST_WRITE;
				else if (status.out_free && status.period_zero) state_d = ST_WRITE;
			end
			ST_WRITE: state_d = idx_last ? ST_DONE : ST_SCAN;
			ST_DONE: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_ready    = 1'b0;
		cmd.op       = OP_NONE;
		cmd.deferred = defer_q;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = status.out_free;
				if (req_valid && status.out_free) cmd.op = OP_ACCEPT;
			end
			ST_SCAN: begin
				if (status.cur_valid) cmd.op = OP_READ;
			end
			ST_LOAD:  cmd.op = OP_LOAD;
			ST_EVAL:  cmd.op = OP_EVAL;
			ST_STEP: begin
				if (status.fire_due && !budget_full && status.out_free) cmd.op = OP_FIRE;
			end
			ST_WRITE: cmd.op = OP_WRITE;
			ST_DONE: begin
				if (status.out_free) cmd.op = OP_DONE;
			end
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			fires_q <= '0;
			defer_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && accept) begin
				idx_q   <= '0;
				fires_q <= '0;
				defer_q <= 1'b0;
			end
			if (((state_q == ST_SCAN && !status.cur_valid) || state_q == ST_WRITE)
					&& !idx_last) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (state_q == ST_STEP && status.fire_due && budget_full) defer_q <= 1'b1;
			if (cmd.op == OP_FIRE) fires_q <= fires_q + BUDGET_W'(1);
		end
	end

endmodule

[rtl/core/rtt_datapath.sv]
// timer entry store, working registers and result register
// depends on rtt_pkg and rtt_if
module rtt_datapath #(
	parameter int NUM_TIMERS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [rtt_pkg::FUNC_W-1:0] func,
	input  rtt_pkg::time_t             time_now,
	input  rtt_pkg::time_t             first_delay,
	input  rtt_pkg::time_t             period,
	input  rtt_pkg::cnt_t              repeat_limit,
	input  logic [rtt_pkg::SLOT_W-1:0] slot,
	input  rtt_pkg::dp_cmd_t           cmd,
	input  logic [((NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1)-1:0] idx,
	output rtt_pkg::dp_status_t        status,
	rtt_out_if.source                  result
);
	import rtt_pkg::*;

	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	logic [NUM_TIMERS-1:0] valid_q;
	entry_t                mem [NUM_TIMERS];
	entry_t                rd_q;
	time_t                 now_q;

	// working copy of the visited entry
	time_t start_q, fd_q, period_q, local_q, next_q;
	cnt_t  limit_q, count_q;
	logic  started_q;

	// result register
	logic              out_valid_q;
	logic [KIND_W-1:0] kind_q;
	logic [SLOT_W-1:0] tslot_q;
	time_t             ftime_q;
	cnt_t              fcount_q;
	logic              defer_q;
	logic              last_q;

	logic              out_free;
	logic              free_found;
	logic [IDX_W-1:0]  free_idx;
	logic              rm_hit;
	logic [TIME_BITS:0] next_sum;
	time_t             next_sat;
	cnt_t              count_inc;
	entry_t            new_entry;
	logic              expired;

	assign out_free = !out_valid_q || result.ready;

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	assign rm_hit = ({1'b0, slot} < (SLOT_W + 1)'(NUM_TIMERS)) && valid_q[slot[IDX_W-1:0]];

	assign next_sum  = {1'b0, next_q} + {1'b0, period_q};
	assign next_sat  = next_sum[TIME_BITS] ? '1 : next_sum[TIME_BITS-1:0];
	assign count_inc = bump(count_q);
	assign expired   = (limit_q != '0) && (count_q >= limit_q);

	always_comb begin
		new_entry.start       = now_q;
		new_entry.first_delay = first_delay;
		new_entry.period      = period;
		new_entry.limit       = repeat_limit;
		new_entry.count       = '0;
		new_entry.started     = 1'b0;
		new_entry.next_fire   = '0;
	end

	assign status.out_free    = out_free;
	assign status.cur_valid   = valid_q[idx];
	assign status.due_ok      = (local_q >= fd_q);
	assign status.period_zero = (period_q == '0);
	assign status.fire_due    = (period_q == '0)
		|| (((limit_q == '0) || (limit_q > count_q)) && (next_q <= local_q));

	// entry store, one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.op == OP_ACCEPT && func == FUNC_ADD && free_found) begin
			mem[free_idx] <= new_entry;
		end else if (cmd.op == OP_WRITE) begin
			mem[idx] <= '{start: start_q, first_delay: fd_q, period: period_q,
				limit: limit_q, count: count_q, started: started_q, next_fire: next_q};
		end
		if (cmd.op == OP_READ) rd_q <= mem[idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			now_q   <= '0;
		end else begin
			if (cmd.op == OP_ACCEPT) begin
				case (func)
					FUNC_ADD: begin
						if (free_found) valid_q[free_idx] <= 1'b1;
					end
					FUNC_REMOVE: begin
						if (rm_hit) valid_q[slot[IDX_W-1:0]] <= 1'b0;
					end
					FUNC_TICK: now_q <= time_now;
					default: ;
				endcase
			end
			if (cmd.op == OP_WRITE && expired) valid_q[idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				start_q   <= rd_q.start;
				fd_q      <= rd_q.first_delay;
				period_q  <= rd_q.period;
				limit_q   <= rd_q.limit;
				count_q   <= rd_q.count;
				started_q <= rd_q.started;
				next_q    <= rd_q.next_fire;
				local_q   <= now_q - rd_q.start;
			end
			OP_EVAL: begin
				if (local_q >= fd_q && !started_q) begin
					started_q <= 1'b1;
					next_q    <= fd_q;
				end
			end
			OP_FIRE: begin
				count_q <= count_inc;
				next_q  <= (period_q == '0) ? local_q : next_sat;
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.op == OP_ACCEPT && func != FUNC_TICK
				&& (func == FUNC_ADD || func == FUNC_REMOVE))
				|| cmd.op == OP_FIRE || cmd.op == OP_DONE) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			tslot_q  <= '0;
			ftime_q  <= '0;
			fcount_q <= '0;
			defer_q  <= 1'b0;
			last_q   <= 1'b1;
			kind_q   <= KIND_TICK_DONE;
			unique case (cmd.op)
				OP_ACCEPT: begin
					if (func == FUNC_ADD) begin
						kind_q  <= free_found ? KIND_ADDED : KIND_FULL;
						tslot_q <= free_found ? SLOT_W'(free_idx) : '0;
					end else begin
						kind_q  <= rm_hit ? KIND_REMOVED : KIND_RM_IGNORED;
						tslot_q <= slot;
					end
				end
				OP_FIRE: begin
					kind_q   <= KIND_FIRED;
					tslot_q  <= SLOT_W'(idx);
					ftime_q  <= (period_q == '0) ? local_q : next_q;
					fcount_q <= count_inc;
					last_q   <= 1'b0;
				end
				OP_DONE: defer_q <= cmd.deferred;
				default: ;
			endcase
		end
	end

	assign result.valid      = out_valid_q;
	assign result.kind       = kind_q;
	assign result.timer_slot = tslot_q;
	assign result.fire_time  = ftime_q;
	assign result.fire_count = fcount_q;
	assign result.deferred   = defer_q;
	assign result.last       = last_q;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// self-checking bench for repeating_timer_table_top: directed and random
// add, remove and tick requests, each result checked against a local timer model
// depends on rtt_pkg, rtt_if and the timer table rtl
module tb;
	import rtt_pkg::*;

	localparam int TIMERS          = 16;
	localparam int FIRE_BUDGET     = 63;
	localparam int RANDOM_ITEMS    = 205;
	localparam int SEGMENT_ITEMS   = 20;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int TAIL_CYCLES     = 100;
	localparam int REPORT_LINES    = 40;

	typedef logic [FUNC_W-1:0] func_t;
	typedef logic [KIND_W-1:0] kind_t;
	typedef logic [SLOT_W-1:0] slot_t;

	// func code that the table takes and drops
	localparam func_t FUNC_UNUSED = 2'd3;

	typedef struct {
		func_t func;
		time_t time_now;
		time_t first_delay;
		time_t period;
		cnt_t  repeat_limit;
		slot_t slot;
	} timer_req_t;

	typedef struct {
		kind_t kind;
		slot_t timer_slot;
		time_t fire_time;
		cnt_t  fire_count;
		logic  deferred;
		logic  last;
	} timer_event_t;

	logic clk;
	logic arst_n;

	rtt_in_if  req_ch();
	rtt_out_if res_ch();

	repeating_timer_table_top #(
		.NUM_TIMERS(TIMERS),
		.MAX_FIRES_PER_TICK(FIRE_BUDGET)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.request(req_ch),
		.result(res_ch)
	);

	// local copy of the timer table
	time_t now_ticks = '0;
	bit    slot_busy    [TIMERS];
	time_t slot_start   [TIMERS];
	time_t slot_delay   [TIMERS];
	time_t slot_period  [TIMERS];
	time_t slot_next    [TIMERS];
	cnt_t  slot_limit   [TIMERS];
	cnt_t  slot_count   [TIMERS];
	bit    slot_started [TIMERS];

	// results owed by the table, oldest first
	timer_event_t pending_events[$];

	// random idling on both channels, and the long receiver hold-off
	bit idle_enable   = 1'b1;
	bit hold_off_req  = 1'b0;

	int mismatches       = 0;
	int requests_taken   = 0;
	int results_seen     = 0;
	int fires_seen       = 0;
	int held_ticks       = 0;
	int full_replies     = 0;
	int removals         = 0;
	int ignored_removals = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic cnt_t count_step(input cnt_t c);
		// saturates at all ones
		return c + cnt_t'(c != '1);
	endfunction

	function automatic void queue_event(input kind_t kind, input slot_t s, input time_t t,
		input cnt_t c, input logic held, input logic fin);
		timer_event_t ev;
		ev.kind       = kind;
		ev.timer_slot = s;
		ev.fire_time  = t;
		ev.fire_count = c;
		ev.deferred   = held;
		ev.last       = fin;
		pending_events.push_back(ev);
	endfunction

	// apply one accepted request to the local table and queue what it produces
	function automatic void advance_timer_table(input timer_req_t rq);
		int    fired;
		logic  held;
		bit    placed;
		bit    stop;
		time_t elapsed;
		time_t due;
		logic [TIME_BITS:0] sum;
		fired  = 0;
		held   = 1'b0;
		placed = 1'b0;
		case (rq.func)
			FUNC_ADD: begin
				for (int i = 0; i < TIMERS; i++) begin
					if (!placed && !slot_busy[i]) begin
						placed          = 1'b1;
						slot_busy[i]    = 1'b1;
						slot_start[i]   = now_ticks;
						slot_delay[i]   = rq.first_delay;
						slot_period[i]  = rq.period;
						slot_limit[i]   = rq.repeat_limit;
						slot_count[i]   = '0;
						slot_started[i] = 1'b0;
						slot_next[i]    = '0;
						queue_event(KIND_ADDED, slot_t'(i), '0, '0, 1'b0, 1'b1);
					end
				end
				if (!placed)
					queue_event(KIND_FULL, '0, '0, '0, 1'b0, 1'b1);
			end
			FUNC_REMOVE: begin
				if (slot_busy[rq.slot]) begin
					slot_busy[rq.slot] = 1'b0;
					queue_event(KIND_REMOVED, rq.slot, '0, '0, 1'b0, 1'b1);
				end else begin
					queue_event(KIND_RM_IGNORED, rq.slot, '0, '0, 1'b0, 1'b1);
				end
			end
			FUNC_TICK: begin
				now_ticks = rq.time_now;
				for (int i = 0; i < TIMERS; i++) begin
					if (slot_busy[i]) begin
						// elapsed time wraps modulo the time width
						elapsed = now_ticks - slot_start[i];
						if (elapsed >= slot_delay[i]) begin
							if (!slot_started[i]) begin
								slot_started[i] = 1'b1;
								slot_next[i]    = slot_delay[i];
							end
							if (slot_period[i] == '0) begin
								// one firing per tick, skipped when the budget is spent
								if (fired < FIRE_BUDGET) begin
									slot_count[i] = count_step(slot_count[i]);
									slot_next[i]  = elapsed;
									queue_event(KIND_FIRED, slot_t'(i), elapsed, slot_count[i],
										1'b0, 1'b0);
									fired++;
								end else begin
									held = 1'b1;
								end
							end else begin
								// catch up on every period that has come due
								stop = 1'b0;
								while (!stop) begin
									due = slot_next[i];
									if (slot_limit[i] != '0 && slot_count[i] >= slot_limit[i]) begin
										stop = 1'b1;
									end else if (due > elapsed) begin
										stop = 1'b1;
									end else if (fired >= FIRE_BUDGET) begin
										held = 1'b1;
										stop = 1'b1;
									end else begin
										slot_count[i] = count_step(slot_count[i]);
										sum = {1'b0, due} + {1'b0, slot_period[i]};
										// next due time sticks at the top of the range
										slot_next[i] = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
										queue_event(KIND_FIRED, slot_t'(i), due, slot_count[i],
											1'b0, 1'b0);
										fired++;
									end
								end
							end
						end
						if (slot_limit[i] != '0 && slot_count[i] >= slot_limit[i])
							slot_busy[i] = 1'b0;
					end
				end
				queue_event(KIND_TICK_DONE, '0, '0, '0, held, 1'b1);
			end
			default: begin
				// unknown code: dropped, nothing owed
			end
		endcase
	endfunction

	function automatic timer_req_t make_request(input func_t func, input time_t t_now,
		input time_t delay, input time_t per, input cnt_t lim, input slot_t s);
		timer_req_t rq;
		rq.func         = func;
		rq.time_now     = t_now;
		rq.first_delay  = delay;
		rq.period       = per;
		rq.repeat_limit = lim;
		rq.slot         = s;
		return rq;
	endfunction

	// sender gap: mostly none, some short, a few long
	function automatic int idle_gap();
		int r;
		if (!idle_enable)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// drive one request and hold it until taken; valid stays high for a back-to-back item
	task automatic send_request(input timer_req_t rq);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.func         <= rq.func;
		req_ch.time_now     <= rq.time_now;
		req_ch.first_delay  <= rq.first_delay;
		req_ch.period       <= rq.period;
		req_ch.repeat_limit <= rq.repeat_limit;
		req_ch.slot         <= rq.slot;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		advance_timer_table(rq);
		requests_taken++;
	endtask

	// random request; mode 1 leans to adds, mode 2 to removes
	function automatic timer_req_t random_request(input int mode);
		timer_req_t rq;
		int pick;
		int r;
		int add_cut;
		int rm_cut;
		int live[$];
		// unused fields carry noise
		rq.func         = FUNC_TICK;
		rq.time_now     = $urandom;
		rq.first_delay  = $urandom;
		rq.period       = $urandom;
		rq.repeat_limit = cnt_t'($urandom);
		rq.slot         = slot_t'($urandom);
		add_cut = (mode == 1) ? 70 : (mode == 2) ? 10 : 30;
		rm_cut  = (mode == 1) ? 10 : (mode == 2) ? 60 : 22;
		pick = $urandom_range(0, 99);
		if (pick >= 97) begin
			rq.func = FUNC_UNUSED;
		end else if (pick < add_cut) begin
			rq.func = FUNC_ADD;
			r = $urandom_range(0, 99);
			if (r < 50)
				rq.first_delay = time_t'($urandom_range(0, 30));
			else if (r < 85)
				rq.first_delay = time_t'($urandom_range(0, 200));
			r = $urandom_range(0, 99);
			if (r < 12)
				rq.period = '0;
			else if (r < 75)
				rq.period = time_t'($urandom_range(1, 15));
			else if (r < 90)
				rq.period = time_t'($urandom_range(16, 500));
			r = $urandom_range(0, 99);
			if (r < 25)
				rq.repeat_limit = '0;
			else if (r < 80)
				rq.repeat_limit = cnt_t'($urandom_range(1, 6));
		end else if (pick < add_cut + rm_cut) begin
			rq.func = FUNC_REMOVE;
			for (int i = 0; i < TIMERS; i++)
				if (slot_busy[i])
					live.push_back(i);
			if (live.size() != 0 && $urandom_range(0, 9) < 8)
				rq.slot = slot_t'(live[$urandom_range(0, live.size() - 1)]);
		end else begin
			r = $urandom_range(0, 99);
			// mostly small steps forward, some jumps, some steps back
			if (r < 80)
				rq.time_now = now_ticks + time_t'($urandom_range(0, 40));
			else if (r < 88)
				rq.time_now = now_ticks + time_t'($urandom_range(0, 5000));
			else if (r < 95)
				rq.time_now = now_ticks - time_t'($urandom_range(1, 100));
		end
		return rq;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= REPORT_LINES)
			$display("mismatch at %0t ns: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// result receiver: random stalls, and a long hold-off when asked
	initial begin : result_ready_drive
		int stall;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n !== 1'b1) begin
				res_ch.ready <= 1'b0;
			end else if (hold_off_req) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
				res_ch.ready <= 1'b1;
			end else if (idle_enable && $urandom_range(0, 99) < 30) begin
				res_ch.ready <= 1'b0;
				stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
				repeat (stall) @(posedge clk);
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// every taken result is matched against the oldest owed one
	always @(posedge clk) begin : result_check
		timer_event_t want;
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			results_seen++;
			if (pending_events.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind %0d slot %0d",
					res_ch.kind, res_ch.timer_slot));
			end else begin
				want = pending_events.pop_front();
				check_field("kind", 32'(res_ch.kind), 32'(want.kind));
				check_field("timer_slot", 32'(res_ch.timer_slot), 32'(want.timer_slot));
				check_field("fire_time", 32'(res_ch.fire_time), 32'(want.fire_time));
				check_field("fire_count", 32'(res_ch.fire_count), 32'(want.fire_count));
				check_field("deferred", 32'(res_ch.deferred), 32'(want.deferred));
				check_field("last", 32'(res_ch.last), 32'(want.last));
				case (want.kind)
					KIND_FIRED:      fires_seen++;
					KIND_TICK_DONE:  held_ticks += int'(want.deferred);
					KIND_FULL:       full_replies++;
					KIND_REMOVED:    removals++;
					KIND_RM_IGNORED: ignored_removals++;
					default: ;
				endcase
			end
		end
	end

	// ends the run when no item moves on either channel for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (arst_n !== 1'b1 || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	// removal on an empty table, and a func code the table drops
	task automatic test_remove_and_unknown();
		send_request(make_request(FUNC_REMOVE, '0, '0, '0, '0, 4'hF));
		send_request(make_request(FUNC_UNUSED, '1, '1, '1, '1, 4'hF));
	endtask

	// one-shot timer freed by its limit, then a live timer removed by hand
	task automatic test_one_shot_and_remove();
		send_request(make_request(FUNC_ADD, '0, '0, '0, 16'd1, '0));
		send_request(make_request(FUNC_TICK, now_ticks, '0, '0, '0, '0));
		// already gone after its single firing
		send_request(make_request(FUNC_REMOVE, '0, '0, '0, '0, '0));
		send_request(make_request(FUNC_ADD, '0, '1, '1, '1, '0));
		send_request(make_request(FUNC_REMOVE, '0, '0, '0, '0, '0));
	endtask

	// catch-up over many periods, the per-tick budget, period zero, time going back
	task automatic test_catch_up_and_budget();
		send_request(make_request(FUNC_TICK, 32'd100, '0, '0, '0, '0));
		// endless, period 3
		send_request(make_request(FUNC_ADD, '0, 32'd5, 32'd3, '0, '0));
		// every tick, three times
		send_request(make_request(FUNC_ADD, '0, '0, '0, 16'd3, '0));
		send_request(make_request(FUNC_TICK, 32'd120, '0, '0, '0, '0));
		// first jump overruns the budget, second uses it exactly, third fires only the every-tick timer
		repeat (3) send_request(make_request(FUNC_TICK, 32'd500, '0, '0, '0, '0));
		// time before the start: elapsed wraps to a huge value
		send_request(make_request(FUNC_TICK, 32'd50, '0, '0, '0, '0));
		send_request(make_request(FUNC_REMOVE, '0, '0, '0, '0, 4'd0));
		send_request(make_request(FUNC_TICK, 32'd60, '0, '0, '0, '0));
	endtask

	// next due time overflows and sticks at the top of the range
	task automatic test_due_time_saturation();
		time_t base;
		base = now_ticks;
		send_request(make_request(FUNC_ADD, '0, 32'hFFFF_FFF0, 32'h20, '0, '0));
		send_request(make_request(FUNC_TICK, base + 32'hFFFF_FFF0, '0, '0, '0, '0));
		send_request(make_request(FUNC_TICK, base + 32'hFFFF_FFFF, '0, '0, '0, '0));
		send_request(make_request(FUNC_REMOVE, '0, '0, '0, '0, 4'd0));
	endtask

	// receiver holds off while adds fill the table past full and ticks fire them all
	task automatic test_stall_and_full_table();
		while (hold_off_req) @(posedge clk);
		hold_off_req = 1'b1;
		for (int i = 0; i <= TIMERS; i++)
			send_request(make_request(FUNC_ADD, '0, time_t'(i), time_t'(1 + i % 4), 16'd3, '0));
		while (hold_off_req) @(posedge clk);
		hold_off_req = 1'b1;
		send_request(make_request(FUNC_TICK, now_ticks + 32'd10, '0, '0, '0, '0));
		send_request(make_request(FUNC_TICK, now_ticks + 32'd10, '0, '0, '0, '0));
		for (int i = 0; i < TIMERS; i++)
			send_request(make_request(FUNC_REMOVE, '0, '0, '0, '0, slot_t'(i)));
	endtask

	// random traffic in segments: mixed, filling, draining, mixed without idling
	task automatic test_random_traffic();
		timer_req_t rq;
		int left;
		int mode;
		left = RANDOM_ITEMS;
		while (left > 0) begin
			mode = $urandom_range(0, 3);
			idle_enable = (mode != 3);
			for (int k = 0; k < SEGMENT_ITEMS && left > 0; k++) begin
				rq = random_request(mode);
				send_request(rq);
				// dropped codes do not count
				if (rq.func != FUNC_UNUSED)
					left--;
			end
		end
		idle_enable = 1'b1;
	endtask

	initial begin : test_sequence
		arst_n              <= 1'b0;
		req_ch.valid        <= 1'b0;
		req_ch.func         <= FUNC_ADD;
		req_ch.time_now     <= '0;
		req_ch.first_delay  <= '0;
		req_ch.period       <= '0;
		req_ch.repeat_limit <= '0;
		req_ch.slot         <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_remove_and_unknown();
		test_one_shot_and_remove();
		test_catch_up_and_budget();
		test_due_time_saturation();
		test_stall_and_full_table();
		test_random_traffic();

		req_ch.valid <= 1'b0;
		// drain what is still owed, then let a dropped request settle
		while (pending_events.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run: %0d requests, %0d results, %0d firings, %0d ticks held back firings",
			requests_taken, results_seen, fires_seen, held_ticks);
		$display("run: %0d table-full replies, %0d removals, %0d ignored removals",
			full_replies, removals, ignored_removals);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

[repeating_timer_table_top.f]
+incdir+rtl/core
rtl/core/rtt_pkg.sv
rtl/core/rtt_if.sv
rtl/core/rtt_ctrl.sv
rtl/core/rtt_datapath.sv
rtl/core/repeating_timer_table_top.sv
tb/tb.sv
